>>> sv/uicf_pkg.sv
// ----------------------------------------------------------------------------
// uicf_pkg: shared types and constants for the UDP/IPv6 checksum fixer
// Frame offsets, protocol codes, register indexes and the stage record
// passed from the frame parser to the checksum fold stage.
// ----------------------------------------------------------------------------
package uicf_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TARGET_PORT = 2'd0,
    REG_MAX_FRAME   = 2'd1
  } cfg_reg_t;

  localparam int CFG_DATA_BITS   = 16;
  localparam int MAX_FRAME_BITS  = 11;

  localparam logic [15:0]               TARGET_PORT_RESET = 16'd4739;
  localparam logic [MAX_FRAME_BITS-1:0] MAX_FRAME_RESET   = 11'd1514;

  // Protocol codes
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  NEXT_HDR_UDP   = 8'd17;

  // Frame layout (byte offsets from the destination MAC)
  localparam int ETH_LEN      = 14;
  localparam int IP6_LEN      = 40;
  localparam int L4_START     = ETH_LEN + IP6_LEN;
  localparam int ADDR_START   = ETH_LEN + 8;
  localparam int NH_POS       = ETH_LEN + 6;
  localparam int ETYPE_LO_POS = 13;
  localparam int DPORT_LO_POS = L4_START + 3;
  localparam int CSUM_LO_POS  = L4_START + 7;
  localparam int MIN_FRAME    = 76;

  // Length term offset: (len - L4_START) + UDP, with len = position + 1
  localparam int LEN_TERM_OFFSET = L4_START - 1 - 17;

  // Record of a finished frame, handed to the fold stage
  typedef struct packed {
    logic        ok;
    logic [31:0] sum;
    logic [15:0] len_term;
  } frame_sum_t;

endpackage

>>> sv/uicf_if.sv
// ----------------------------------------------------------------------------
// uicf_if: channel interfaces of the UDP/IPv6 checksum fixer
// Byte stream in, result out and configuration write, each valid/ready.
// ----------------------------------------------------------------------------
interface uicf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface uicf_result_if;
  logic        valid;
  logic        ready;
  logic        apply_fix;
  logic [15:0] checksum;

  modport source (output valid, output apply_fix, output checksum, input ready);
  modport sink   (input valid, input apply_fix, input checksum, output ready);
endinterface

interface uicf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/udp_ipv6_checksum_fixer_top.sv
// ----------------------------------------------------------------------------
// udp_ipv6_checksum_fixer_top: UDP-over-IPv6 checksum recomputation
// Watches an Ethernet byte stream and, at each frame end, reports whether
// the frame is untagged IPv6/UDP to the configured port within the length
// limits, together with the recomputed UDP checksum.
//
//   channel      role    words                         payload
//   byte_in      sink    one frame byte                data_byte, last
//   result_out   source  one per frame (on last byte)  apply_fix, checksum
//   cfg          sink    register write                index, data
//
// One byte is taken every cycle while the result side keeps up. A byte
// passes an input register, then the frame parser (one add per byte); the
// last byte's sum is held in the finished-frame record, then goes through
// the fold stage into the result register.
// rst is synchronous: it clears the frame state, empties every stage and
// loads the register defaults. A stalled result holds the output register;
// bytes keep flowing until a frame end finds both the finished-frame record
// and the output register occupied.
// ----------------------------------------------------------------------------
module udp_ipv6_checksum_fixer_top
  import uicf_pkg::*;
#(
  parameter int LENGTH_BITS = 11
) (
  input  logic          clk,
  input  logic          rst,
  uicf_byte_if.sink     byte_in,
  uicf_result_if.source result_out,
  uicf_cfg_if.sink      cfg
);

  // Configuration registers
  logic [15:0]               target_port;
  logic [MAX_FRAME_BITS-1:0] max_frame_bytes;

  // Input register
  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_last;
  logic       consume;

  // Parser to fold stage
  logic       sum_vld;
  frame_sum_t sum_rec;
  logic       sum_take;

  // Register writes are always taken; unknown indexes drop silently.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_port     <= TARGET_PORT_RESET;
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TARGET_PORT: target_port     <= cfg.data;
        REG_MAX_FRAME:   max_frame_bytes <= cfg.data[MAX_FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Take a new byte whenever the held one moves on to the parser.
  assign byte_in.ready = !in_vld || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (byte_in.ready) begin
      in_vld <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.data_byte;
      in_last <= byte_in.last;
    end
  end

  uicf_frame #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_frame (
    .clk             (clk),
    .rst             (rst),
    .in_vld          (in_vld),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .consume         (consume),
    .target_port     (target_port),
    .max_frame_bytes (max_frame_bytes),
    .sum_vld         (sum_vld),
    .sum_rec         (sum_rec),
    .sum_take        (sum_take)
  );

  uicf_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .sum_vld  (sum_vld),
    .sum_rec  (sum_rec),
    .sum_take (sum_take),
    .result   (result_out)
  );

endmodule

>>> sv/uicf_frame.sv
// ----------------------------------------------------------------------------
// uicf_frame: per-frame parser and word accumulator
// Tracks position, header checks and the running checksum sum, and hands
// a finished-frame record to the fold stage on the last byte.
// ----------------------------------------------------------------------------
module uicf_frame
  import uicf_pkg::*;
#(
  parameter int LENGTH_BITS = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic [7:0]                in_byte,
  input  logic                      in_last,
  output logic                      consume,
  input  logic [15:0]               target_port,
  input  logic [MAX_FRAME_BITS-1:0] max_frame_bytes,
  output logic                      sum_vld,
  output frame_sum_t                sum_rec,
  input  logic                      sum_take
);

  localparam logic [LENGTH_BITS-1:0] POS_SAT = '1;

  logic [LENGTH_BITS-1:0] byte_position, byte_position_next;
  logic [31:0]            sum_accumulator, sum_accumulator_next;
  logic [7:0]             pending_high_byte, pending_high_byte_next;
  logic                   ethertype_ok, ethertype_ok_next;
  logic                   protocol_ok, protocol_ok_next;
  logic [15:0]            port_seen, port_seen_next;

  logic                   counted;
  logic                   sum_free;
  logic [15:0]            word;
  logic [LENGTH_BITS-1:0] len;
  logic                   frame_ok;

  assign sum_free = !sum_vld || sum_take;
  assign consume  = in_vld && (!in_last || sum_free);

  assign counted = (byte_position != POS_SAT);
  assign word    = {pending_high_byte, in_byte};
  assign len     = byte_position + LENGTH_BITS'(1);

  always_comb begin
    byte_position_next     = byte_position;
    sum_accumulator_next   = sum_accumulator;
    pending_high_byte_next = pending_high_byte;
    ethertype_ok_next      = ethertype_ok;
    protocol_ok_next       = protocol_ok;
    port_seen_next         = port_seen;
    if (counted) begin
      byte_position_next = len;
      if (byte_position == LENGTH_BITS'(ETYPE_LO_POS)) begin
        ethertype_ok_next = (word == ETHERTYPE_IPV6);
      end
      if (byte_position == LENGTH_BITS'(NH_POS)) begin
        protocol_ok_next = (in_byte == NEXT_HDR_UDP);
      end
      if (byte_position == LENGTH_BITS'(DPORT_LO_POS)) begin
        port_seen_next = word;
      end
      if (byte_position[0]) begin
        // odd position: close a word, skip the checksum field
        if (byte_position > LENGTH_BITS'(ADDR_START) &&
            byte_position != LENGTH_BITS'(CSUM_LO_POS)) begin
          sum_accumulator_next = sum_accumulator + 32'(word);
        end
      end else begin
        pending_high_byte_next = in_byte;
        // odd frame length: pad the final byte with a zero low byte
        if (in_last && byte_position >= LENGTH_BITS'(ADDR_START) &&
            byte_position != LENGTH_BITS'(CSUM_LO_POS - 1)) begin
          sum_accumulator_next = sum_accumulator + {16'd0, in_byte, 8'd0};
        end
      end
    end
  end

  assign frame_ok = counted &&
                    len >= LENGTH_BITS'(MIN_FRAME) &&
                    32'(len) <= 32'(max_frame_bytes) &&
                    ethertype_ok_next && protocol_ok_next &&
                    port_seen_next == target_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      sum_accumulator   <= '0;
      pending_high_byte <= '0;
      ethertype_ok      <= 1'b0;
      protocol_ok       <= 1'b0;
      port_seen         <= '0;
    end else if (consume) begin
      if (in_last) begin
        byte_position     <= '0;
        sum_accumulator   <= '0;
        pending_high_byte <= '0;
        ethertype_ok      <= 1'b0;
        protocol_ok       <= 1'b0;
        port_seen         <= '0;
      end else begin
        byte_position     <= byte_position_next;
        sum_accumulator   <= sum_accumulator_next;
        pending_high_byte <= pending_high_byte_next;
        ethertype_ok      <= ethertype_ok_next;
        protocol_ok       <= protocol_ok_next;
        port_seen         <= port_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else if (consume && in_last) begin
      sum_vld <= 1'b1;
    end else if (sum_take) begin
      sum_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      sum_rec.ok       <= frame_ok;
      sum_rec.sum      <= sum_accumulator_next;
      sum_rec.len_term <= 16'(byte_position) - 16'(LEN_TERM_OFFSET);
    end
  end

endmodule

>>> sv/uicf_fold.sv
// ----------------------------------------------------------------------------
// uicf_fold: checksum fold and result register
// Adds the length and protocol term, folds to 16 bits, inverts, and holds
// the result until the sink takes it.
// ----------------------------------------------------------------------------
module uicf_fold
  import uicf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sum_vld,
  input  frame_sum_t            sum_rec,
  output logic                  sum_take,
  uicf_result_if.source         result
);

  logic        out_free;
  logic [31:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum;

  assign out_free = !result.valid || result.ready;
  assign sum_take = sum_vld && out_free;

  assign total = sum_rec.sum + 32'(sum_rec.len_term);
  assign fold1 = 17'(total[31:16]) + 17'(total[15:0]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign csum  = (~fold2 == 16'd0) ? 16'hFFFF : ~fold2;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (sum_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_take) begin
      result.apply_fix <= sum_rec.ok;
      result.checksum  <= sum_rec.ok ? csum : 16'd0;
    end
  end

endmodule
